// File: rtl/u8cd_pkg.sv
package u8cd_pkg;

    localparam int unsigned CpWidth = 21;
    localparam int unsigned QueueDepth = 2;

    // One queue entry: the results caused by one input byte (one or two).
    typedef struct packed {
        logic [CpWidth-1:0] cp0;
        logic [CpWidth-1:0] cp1;
        logic               two;
    } u8cd_entry_t;

endpackage

// File: rtl/u8cd_front.sv
module u8cd_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 accept,
    input  logic [7:0]           text_byte,
    input  logic                 end_of_text,
    output logic                 push,
    output u8cd_pkg::u8cd_entry_t push_data
);
    import u8cd_pkg::*;

    // sequence length from lead byte, 0 = not a lead
    function automatic logic [2:0] lead_len(input logic [7:0] b);
        logic [2:0] len;
        begin
            if (b[7] == 1'b0)
                len = 3'd1;
            else if (b[7:5] == 3'b110)
                len = 3'd2;
            else if (b[7:4] == 4'b1110)
                len = 3'd3;
            else if (b[7:3] == 5'b11110)
                len = 3'd4;
            else
                len = 3'd0;
            return len;
        end
    endfunction

    function automatic logic [CpWidth-1:0] assemble(
        input logic [2:0] len,
        input logic [7:0] b0,
        input logic [7:0] b1,
        input logic [7:0] b2,
        input logic [7:0] b3
    );
        logic [CpWidth-1:0] cp;
        begin
            case (len)
                3'd1:    cp = {13'd0, b0};
                3'd2:    cp = {10'd0, b0[4:0], b1[5:0]};
                3'd3:    cp = {5'd0, b0[3:0], b1[5:0], b2[5:0]};
                3'd4:    cp = {b0[2:0], b1[5:0], b2[5:0], b3[5:0]};
                default: cp = '0;
            endcase
            return cp;
        end
    endfunction

    // single-byte code point that survives the control-char filter
    function automatic logic ascii_ok(input logic [7:0] b);
        return (b[7] == 1'b0) && (b[6:5] != 2'b00);
    endfunction

    logic [1:0] count_reg, count_next;
    logic [7:0] h0_reg, h0_next;
    logic [7:0] h1_reg, h1_next;
    logic [7:0] h2_reg, h2_next;

    logic [CpWidth-1:0] e0, e1;
    logic               e0_ok, e1_ok;
    logic [2:0]         len_in, len_held, len_d0, total;
    logic [7:0]         d0, b1, b2;

    always_comb
    begin
        count_next = count_reg;
        h0_next    = h0_reg;
        h1_next    = h1_reg;
        h2_next    = h2_reg;
        e0         = '0;
        e1         = '0;
        e0_ok      = 1'b0;
        e1_ok      = 1'b0;
        len_in     = lead_len(text_byte);
        len_held   = lead_len(h0_reg);
        total      = {1'b0, count_reg} + 3'd1;
        b1         = (count_reg == 2'd1) ? text_byte : h1_reg;
        b2         = (count_reg == 2'd2) ? text_byte : h2_reg;
        d0         = b1;
        len_d0     = lead_len(d0);

        if (count_reg == 2'd0)
        begin
            if (len_in == 3'd1)
            begin
                e0    = {13'd0, text_byte};
                e0_ok = ascii_ok(text_byte);
            end
            else if (len_in != 3'd0 && !end_of_text)
            begin
                h0_next    = text_byte;
                count_next = 2'd1;
            end
        end
        else if (total == len_held)
        begin
            e0         = assemble(len_held, h0_reg, b1, b2, text_byte);
            e0_ok      = (e0[CpWidth-1:5] != '0);
            count_next = 2'd0;
        end
        else if (end_of_text)
        begin
            // drop the lead, re-decode the trailing one or two bytes
            count_next = 2'd0;
            if (count_reg == 2'd1)
            begin
                e0    = {13'd0, d0};
                e0_ok = (len_d0 == 3'd1) && ascii_ok(d0);
            end
            else if (len_d0 == 3'd1)
            begin
                e0    = {13'd0, d0};
                e0_ok = ascii_ok(d0);
                e1    = {13'd0, text_byte};
                e1_ok = ascii_ok(text_byte);
            end
            else if (len_d0 == 3'd2)
            begin
                e0    = assemble(3'd2, d0, text_byte, 8'd0, 8'd0);
                e0_ok = (e0[CpWidth-1:5] != '0);
            end
            else
            begin
                e1    = {13'd0, text_byte};
                e1_ok = ascii_ok(text_byte);
            end
        end
        else
        begin
            case (count_reg)
                2'd1:    h1_next = text_byte;
                2'd2:    h2_next = text_byte;
                default: ;
            endcase
            count_next = count_reg + 2'd1;
        end
    end

    always_comb
    begin
        push           = accept && (e0_ok || e1_ok);
        push_data.cp0  = e0_ok ? e0 : e1;
        push_data.cp1  = e1;
        push_data.two  = e0_ok && e1_ok;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= 2'd0;
        else if (accept)
            count_reg <= count_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            h0_reg <= h0_next;
            h1_reg <= h1_next;
            h2_reg <= h2_next;
        end
    end

endmodule

// File: rtl/u8cd_queue.sv
module u8cd_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  u8cd_pkg::u8cd_entry_t push_data,
    output logic                  full,
    input  logic                  pop,
    output u8cd_pkg::u8cd_entry_t pop_data,
    output logic                  empty
);
    import u8cd_pkg::*;

    localparam int unsigned PtrW = $clog2(QueueDepth);

    u8cd_entry_t         slot_reg [QueueDepth];
    logic [PtrW-1:0]     wr_ptr_reg, rd_ptr_reg;
    logic [PtrW:0]       fill_reg;
    logic                do_push, do_pop;

    assign full     = (fill_reg == (PtrW+1)'(QueueDepth));
    assign empty    = (fill_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == PtrW'(QueueDepth-1)) ? '0 : wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == PtrW'(QueueDepth-1)) ? '0 : rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                fill_reg <= fill_reg + 1'b1;
            else if (do_pop && !do_push)
                fill_reg <= fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_data;
    end

endmodule

// File: rtl/u8cd_back.sv
module u8cd_back (
    input  logic                  clk,
    input  logic                  rst_n,
    output logic                  pop,
    input  u8cd_pkg::u8cd_entry_t pop_data,
    input  logic                  empty,
    output logic                  cp_valid,
    input  logic                  cp_ready,
    output logic [20:0]           code_point,
    output logic                  last_of_run
);
    import u8cd_pkg::*;

    u8cd_entry_t entry_reg;
    logic        valid_reg;
    logic        phase_reg;
    logic        take;

    // free when idle or when the final result of the entry leaves
    assign take        = !valid_reg || (cp_ready && (phase_reg || !entry_reg.two));
    assign pop         = take && !empty;
    assign cp_valid    = valid_reg;
    assign code_point  = phase_reg ? entry_reg.cp1 : entry_reg.cp0;
    assign last_of_run = phase_reg || !entry_reg.two;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            phase_reg <= 1'b0;
        end
        else if (pop)
        begin
            valid_reg <= 1'b1;
            phase_reg <= 1'b0;
        end
        else if (take)
        begin
            valid_reg <= 1'b0;
            phase_reg <= 1'b0;
        end
        else if (cp_ready)
            phase_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            entry_reg <= pop_data;
    end

endmodule

// File: rtl/utf8_codepoint_decoder.sv
// Channel   Valid / ready            Payload
// input     byte_valid / byte_ready  text_byte[7:0], end_of_text
// output    cp_valid / cp_ready      code_point[20:0], last_of_run
//
// One byte is taken per cycle while the two-entry queue between front and
// back has room; a byte that yields two code points (string end inside a
// sequence) holds the back end, the one output register, until both have left.
// cp_valid rises once a result has moved from its queue slot into the output register.
// rst_n clears the held-byte count, queue pointers and output valid.
// A stalled output fills the queue, then byte_ready drops.
module utf8_codepoint_decoder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        byte_valid,
    output logic        byte_ready,
    input  logic [7:0]  text_byte,
    input  logic        end_of_text,
    output logic        cp_valid,
    input  logic        cp_ready,
    output logic [20:0] code_point,
    output logic        last_of_run
);
    import u8cd_pkg::*;

    logic        accept;
    logic        push, full, pop, empty;
    u8cd_entry_t push_data, pop_data;

    // Front never stalls on its own: readiness is only queue space.
    assign byte_ready = !full;
    assign accept     = byte_valid && byte_ready;

    // Front: holds partial sequences and turns each byte into 0..2 results.
    u8cd_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .text_byte   (text_byte),
        .end_of_text (end_of_text),
        .push        (push),
        .push_data   (push_data)
    );

    // Queue: decouples byte intake from result delivery.
    u8cd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (empty)
    );

    // Back: serializes each entry into one or two output transactions.
    u8cd_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .pop         (pop),
        .pop_data    (pop_data),
        .empty       (empty),
        .cp_valid    (cp_valid),
        .cp_ready    (cp_ready),
        .code_point  (code_point),
        .last_of_run (last_of_run)
    );

endmodule
